// ===== rtl/dtb_pkg.sv =====
// ----------------------------------------------------------------------------
// dtb_pkg: shared types and constants of the delay timer bank
// Widths, register indexes, command codes and the front-to-back command type.
// ----------------------------------------------------------------------------
`default_nettype none

package dtb_pkg;

    localparam int SLOTS_DEF   = 8;
    localparam int TASKS_DEF   = 256;
    localparam int MAX_RESULTS = 8;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    localparam int DATA_W = 32;
    localparam int TASK_W = 8;

    // Two 32-bit registers at byte addresses 0 and 4.
    localparam int PADDR_W     = 3;
    localparam int REG_IDX_BIT = 2;

    localparam logic REG_STARTED = 1'b0;
    localparam logic REG_TPS     = 1'b1;

    localparam logic [DATA_W-1:0] TPS_RESET = 32'd1000;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_DELAY = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_STOP,
        KIND_REQ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [TASK_W-1:0]  task_id;
        logic [DATA_W-1:0]  delay;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/dtb_channels.sv =====
// ----------------------------------------------------------------------------
// dtb_channels: valid/ready channels of the delay timer bank
// Input channel carries commands, output channel carries result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtb_in_if import dtb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [TASK_W-1:0]  task_id;
    logic [DATA_W-1:0]  delay_ticks;

    modport source (output valid, output command, output task_id, output delay_ticks,
                    input ready);
    modport sink   (input valid, input command, input task_id, input delay_ticks,
                    output ready);
endinterface

interface dtb_out_if import dtb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               expired_valid;
    logic [TASK_W-1:0]  expired_task;
    logic               accepted;
    logic [DATA_W-1:0]  elapsed_ticks;
    logic [DATA_W-1:0]  remaining_ticks;
    logic               last;

    modport source (output valid, output expired_valid, output expired_task,
                    output accepted, output elapsed_ticks, output remaining_ticks,
                    output last, input ready);
    modport sink   (input valid, input expired_valid, input expired_task,
                    input accepted, input elapsed_ticks, input remaining_ticks,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/delay_timer_bank.sv =====
// ----------------------------------------------------------------------------
// delay_timer_bank: bank of one-shot task delay timers
// Registration-ordered timers with expiry reporting on each system tick.
//
//   channel   dir   handshake            beat
//   i_in_ch   in    valid/ready          command, task_id, delay_ticks
//   o_out_ch  out   valid/ready          expiry, accepted, tick counts, last
//   apb       in    psel/penable/pready  started (0x0), ticks_per_second (0x4)
//
// A delay request or a stopped tick is answered from the engine's idle state.
// A running tick starts, then sweeps the live slots one by one through the
// slot memory, compacting survivors as it goes, and then sends the final beat.
// A two-entry command queue lets input beats land while the engine sweeps.
// Reset is synchronous; the slot memory needs no clearing pass.
// A stalled output holds the sweep only when a further expiry must leave.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_timer_bank import dtb_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int TASKS = TASKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dtb_in_if.sink              i_in_ch,
    dtb_out_if.source           o_out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int CW = $clog2(SLOTS + 1);

    logic               r_started;
    logic [DATA_W-1:0]  r_tps;

    logic               w_push;
    t_cmd               w_push_cmd;
    logic               w_q_ready;
    logic               w_q_valid;
    t_cmd               w_q_cmd;
    logic               w_pop;
    logic [CW-1:0]      w_live;
    logic [DATA_W-1:0]  w_elapsed;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_tps     <= TPS_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[REG_IDX_BIT])
                REG_STARTED: r_started <= pwdata[0];
                REG_TPS:     r_tps     <= pwdata;
                default:     r_tps     <= r_tps;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[REG_IDX_BIT])
            REG_STARTED: prdata = {{(DATA_W-1){1'b0}}, r_started};
            REG_TPS:     prdata = r_tps;
            default:     prdata = '0;
        endcase
    end

    dtb_front #(
        .TASKS (TASKS)
    ) u_front (
        .i_started (r_started),
        .i_in      (i_in_ch),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    dtb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_cmd),
        .i_pop   (w_pop)
    );

    dtb_engine #(
        .SLOTS (SLOTS),
        .TASKS (TASKS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tps     (r_tps),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_pop     (w_pop),
        .o_out     (o_out_ch),
        .o_live    (w_live),
        .o_elapsed (w_elapsed)
    );

    // The bank never holds more live timers than it has slots.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_live <= CW'(SLOTS))
        else $error("live timer count exceeds slot count");

    // The elapsed counter only ever steps by one.
    a_elapsed_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(w_elapsed)) |-> (w_elapsed == $past(w_elapsed) + 32'd1))
        else $error("elapsed counter jumped");

    // Only an expiry beat can be followed by more beats of the same item.
    a_last_only_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && !o_out_ch.last) |-> o_out_ch.expired_valid)
        else $error("non-final beat without an expiry");

    // The engine never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== rtl/dtb_front.sv =====
// ----------------------------------------------------------------------------
// dtb_front: command classifier
// Sorts each input beat into a delay request, a running tick or a stopped
// tick, folds the task id into range and turns a zero delay into one.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_front import dtb_pkg::*; #(
    parameter int TASKS = TASKS_DEF
) (
    input  logic    i_started,
    dtb_in_if.sink  i_in,
    input  logic    i_q_ready,
    output logic    o_push,
    output t_cmd    o_cmd
);

    localparam int TAB_N = 2 ** TASK_W;

    logic [TASK_W-1:0] w_mod_tab [TAB_N];

    // Task id modulo TASKS, worked out at elaboration.
    for (genvar v = 0; v < TAB_N; v++) begin : g_mod_tab
        assign w_mod_tab[v] = TASK_W'(v % TASKS);
    end

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        if (i_in.command == CMD_DELAY) begin
            o_cmd.kind = KIND_REQ;
        end else if (i_started) begin
            o_cmd.kind = KIND_TICK;
        end else begin
            o_cmd.kind = KIND_STOP;
        end
        o_cmd.task_id = w_mod_tab[i_in.task_id];
        o_cmd.delay   = (i_in.delay_ticks == '0) ? DATA_W'(1) : i_in.delay_ticks;
    end

endmodule

`default_nettype wire

// ===== rtl/dtb_queue.sv =====
// ----------------------------------------------------------------------------
// dtb_queue: command queue
// Short first-in first-out buffer between the classifier and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_queue import dtb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_cmd    o_data,
    input  logic    i_pop
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    assign o_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dtb_engine.sv =====
// ----------------------------------------------------------------------------
// dtb_engine: timer bank and result sequencer
// Holds the slot memory, appends delay requests and sweeps the live slots
// once per running tick, compacting survivors and emitting expiries.
// ----------------------------------------------------------------------------
`default_nettype none

module dtb_engine import dtb_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int TASKS = TASKS_DEF,
    localparam int CW   = $clog2(SLOTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [DATA_W-1:0]   i_tps,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_pop,
    dtb_out_if.source           o_out,
    output logic [CW-1:0]       o_live,
    output logic [DATA_W-1:0]   o_elapsed
);

    localparam int IW = $clog2(SLOTS);
    localparam int TW = $clog2(TASKS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_live, n_live;
    logic [DATA_W-1:0]  r_elapsed, n_elapsed;
    logic [IW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_kept, n_kept;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic               r_pend_v, n_pend_v;
    logic [TW-1:0]      r_pend_task, n_pend_task;

    logic               r_out_valid, n_out_valid;
    logic               r_out_exp, n_out_exp;
    logic [TASK_W-1:0]  r_out_task, n_out_task;
    logic               r_out_acc, n_out_acc;
    logic [DATA_W-1:0]  r_out_elapsed, n_out_elapsed;
    logic [DATA_W-1:0]  r_out_rem, n_out_rem;
    logic               r_out_last, n_out_last;

    logic [DATA_W-1:0]  r_mem_cnt  [SLOTS];
    logic [TW-1:0]      r_mem_task [SLOTS];
    logic [DATA_W-1:0]  r_rd_cnt;
    logic [TW-1:0]      r_rd_task;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [DATA_W-1:0]  w_wcnt;
    logic [TW-1:0]      w_wtask;
    logic [IW-1:0]      w_raddr;

    logic               w_out_free;
    logic [DATA_W-1:0]  w_dec;
    logic               w_exp;
    logic               w_last_idx;

    assign w_out_free = !r_out_valid || o_out.ready;
    // A timer already parked at zero stays at zero.
    assign w_dec      = (r_rd_cnt != '0) ? (r_rd_cnt - DATA_W'(1)) : '0;
    assign w_exp      = (w_dec == '0) && (r_nres < NRES_W'(MAX_RESULTS));
    assign w_last_idx = ((CW'(r_idx) + CW'(1)) == r_live);

    always_comb begin
        n_state       = r_state;
        n_live        = r_live;
        n_elapsed     = r_elapsed;
        n_idx         = r_idx;
        n_kept        = r_kept;
        n_nres        = r_nres;
        n_pend_v      = r_pend_v;
        n_pend_task   = r_pend_task;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_exp     = r_out_exp;
        n_out_task    = r_out_task;
        n_out_acc     = r_out_acc;
        n_out_elapsed = r_out_elapsed;
        n_out_rem     = r_out_rem;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_kept[IW-1:0];
        w_wcnt        = w_dec;
        w_wtask       = r_rd_task;
        w_raddr       = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                w_raddr = '0;
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        KIND_REQ: begin
                            if (w_out_free) begin
                                o_pop         = 1'b1;
                                n_out_valid   = 1'b1;
                                n_out_exp     = 1'b0;
                                n_out_task    = '0;
                                n_out_acc     = (r_live < CW'(SLOTS));
                                n_out_elapsed = r_elapsed;
                                n_out_rem     = i_tps - r_elapsed;
                                n_out_last    = 1'b1;
                                if (r_live < CW'(SLOTS)) begin
                                    w_we    = 1'b1;
                                    w_waddr = r_live[IW-1:0];
                                    w_wcnt  = i_q_cmd.delay;
                                    w_wtask = i_q_cmd.task_id[TW-1:0];
                                    n_live  = r_live + CW'(1);
                                end
                            end
                        end
                        KIND_STOP: begin
                            if (w_out_free) begin
                                o_pop         = 1'b1;
                                n_out_valid   = 1'b1;
                                n_out_exp     = 1'b0;
                                n_out_task    = '0;
                                n_out_acc     = 1'b0;
                                n_out_elapsed = r_elapsed;
                                n_out_rem     = i_tps - r_elapsed;
                                n_out_last    = 1'b1;
                            end
                        end
                        KIND_TICK: begin
                            o_pop     = 1'b1;
                            n_elapsed = r_elapsed + DATA_W'(1);
                            n_idx     = '0;
                            n_kept    = '0;
                            n_nres    = '0;
                            n_pend_v  = 1'b0;
                            n_state   = (r_live == '0) ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // An expiry is held back one step so the final one can carry last.
                if (w_exp && r_pend_v && !w_out_free) begin
                    w_raddr = r_idx;
                end else begin
                    w_raddr = r_idx + IW'(1);
                    n_idx   = r_idx + IW'(1);
                    if (w_exp) begin
                        if (r_pend_v) begin
                            n_out_valid   = 1'b1;
                            n_out_exp     = 1'b1;
                            n_out_task    = TASK_W'(r_pend_task);
                            n_out_acc     = 1'b0;
                            n_out_elapsed = r_elapsed;
                            n_out_rem     = i_tps - r_elapsed;
                            n_out_last    = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_task = r_rd_task;
                        n_nres      = r_nres + NRES_W'(1);
                    end else begin
                        w_we   = 1'b1;
                        n_kept = r_kept + CW'(1);
                    end
                    if (w_last_idx) begin
                        n_live  = n_kept;
                        n_state = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_exp     = r_pend_v;
                    n_out_task    = r_pend_v ? TASK_W'(r_pend_task) : '0;
                    n_out_acc     = 1'b0;
                    n_out_elapsed = r_elapsed;
                    n_out_rem     = i_tps - r_elapsed;
                    n_out_last    = 1'b1;
                    n_pend_v      = 1'b0;
                    n_state       = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_cnt[w_waddr]  <= w_wcnt;
            r_mem_task[w_waddr] <= w_wtask;
        end
        r_rd_cnt  <= r_mem_cnt[w_raddr];
        r_rd_task <= r_mem_task[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_live      <= '0;
            r_elapsed   <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_elapsed   <= n_elapsed;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
        r_idx         <= n_idx;
        r_kept        <= n_kept;
        r_nres        <= n_nres;
        r_pend_task   <= n_pend_task;
        r_out_exp     <= n_out_exp;
        r_out_task    <= n_out_task;
        r_out_acc     <= n_out_acc;
        r_out_elapsed <= n_out_elapsed;
        r_out_rem     <= n_out_rem;
        r_out_last    <= n_out_last;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.expired_valid   = r_out_exp;
    assign o_out.expired_task    = r_out_task;
    assign o_out.accepted        = r_out_acc;
    assign o_out.elapsed_ticks   = r_out_elapsed;
    assign o_out.remaining_ticks = r_out_rem;
    assign o_out.last            = r_out_last;

    assign o_live    = r_live;
    assign o_elapsed = r_elapsed;

endmodule

`default_nettype wire

// ===== tb/sv/delay_timer_bank_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delay_timer_bank_tb: self-checking testbench of the delay timer bank
// Drives delay requests and system ticks through the command channel, writes
// the two registers over the APB port between phases, and compares every
// result beat with the beats predicted by a cycle-free model of the bank.
// ----------------------------------------------------------------------------

module delay_timer_bank_tb;
    import dtb_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int TASKS       = TASKS_DEF;
    localparam int PHASE_BEATS = 18;
    localparam int HOLD_CYCLES = 300;
    // The longest quiet stretch of a correct run is the receiver hold-off
    // plus one sweep of the bank; this is many times that.
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic               expired_valid;
        logic [TASK_W-1:0]  expired_task;
        logic               accepted;
        logic [DATA_W-1:0]  elapsed_ticks;
        logic [DATA_W-1:0]  remaining_ticks;
        logic               last;
    } t_beat;

    // Keeps its own copy of the timer list and predicts the beats of each
    // accepted command, then checks the beats that leave the block in order.
    class expiry_scoreboard;
        bit                 run_on;
        logic [DATA_W-1:0]  tick_rate;
        logic [DATA_W-1:0]  elapsed;
        logic [DATA_W-1:0]  count_q [SLOTS];
        logic [TASK_W-1:0]  owner_q [SLOTS];
        int                 live;
        t_beat              pending_beats [$];
        int                 fail_count;

        function new();
            run_on     = 1'b0;
            tick_rate  = TPS_RESET;
            elapsed    = '0;
            live       = 0;
            fail_count = 0;
        endfunction

        function void push_beat(logic hit, logic [TASK_W-1:0] tid, logic acc, logic fin);
            t_beat b;
            b.expired_valid   = hit;
            b.expired_task    = tid;
            b.accepted        = acc;
            b.elapsed_ticks   = elapsed;
            b.remaining_ticks = tick_rate - elapsed;
            b.last            = fin;
            pending_beats.push_back(b);
        endfunction

        function void note_command(logic cmd, logic [TASK_W-1:0] tid, logic [DATA_W-1:0] dly);
            logic [TASK_W-1:0] fired [MAX_RESULTS];
            logic [TASK_W-1:0] stored_id;
            logic [DATA_W-1:0] c;
            int                n;
            int                kept;
            n = 0;
            kept = 0;
            stored_id = TASK_W'(int'(tid) % TASKS);
            if (cmd == CMD_DELAY) begin
                if (live < SLOTS) begin
                    owner_q[live] = stored_id;
                    count_q[live] = (dly == '0) ? DATA_W'(1) : dly;
                    live++;
                    push_beat(1'b0, '0, 1'b1, 1'b1);
                end else begin
                    push_beat(1'b0, '0, 1'b0, 1'b1);
                end
            end else if (!run_on) begin
                push_beat(1'b0, '0, 1'b0, 1'b1);
            end else begin
                elapsed = elapsed + 1;
                for (int i = 0; i < live; i++) begin
                    c = count_q[i];
                    if (c != '0) c = c - 1;
                    // Expired timers leave the list; the rest close up in order.
                    if (c == '0 && n < MAX_RESULTS) begin
                        fired[n] = owner_q[i];
                        n++;
                    end else begin
                        count_q[kept] = c;
                        owner_q[kept] = owner_q[i];
                        kept++;
                    end
                end
                live = kept;
                if (n == 0) push_beat(1'b0, '0, 1'b0, 1'b1);
                for (int k = 0; k < n; k++) push_beat(1'b1, fired[k], 1'b0, k == n - 1);
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            bit    bad;
            if (pending_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result beat with none expected: valid=%0b task=%0d last=%0b",
                             $realtime, got.expired_valid, got.expired_task, got.last);
                return;
            end
            want = pending_beats.pop_front();
            bad = (got.expired_valid !== want.expired_valid) ||
                  (got.expired_task !== want.expired_task) ||
                  (got.accepted !== want.accepted) ||
                  (got.elapsed_ticks !== want.elapsed_ticks) ||
                  (got.remaining_ticks !== want.remaining_ticks) ||
                  (got.last !== want.last);
            if (bad) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: beat mismatch", $realtime);
                    $display("  expected valid=%0b task=%0d acc=%0b elapsed=%0d remain=%0d last=%0b",
                             want.expired_valid, want.expired_task, want.accepted,
                             want.elapsed_ticks, want.remaining_ticks, want.last);
                    $display("  actual   valid=%0b task=%0d acc=%0b elapsed=%0d remain=%0d last=%0b",
                             got.expired_valid, got.expired_task, got.accepted,
                             got.elapsed_ticks, got.remaining_ticks, got.last);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    dtb_in_if  in_ch ();
    dtb_out_if out_ch ();

    expiry_scoreboard sb;
    t_beat            seen_beat;
    bit               steady = 1'b0;
    int               hold_len = 0;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    delay_timer_bank #(
        .SLOTS (SLOTS),
        .TASKS (TASKS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one command beat and returns at the falling edge after it was
    // taken, leaving valid high so that a following beat can go back to back.
    task automatic send_command(input logic cmd, input logic [TASK_W-1:0] tid,
                                input logic [DATA_W-1:0] dly);
        while (!steady && $urandom_range(99) < 36) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.task_id     <= tid;
        in_ch.delay_ticks <= dly;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_command(cmd, tid, dly);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending_beats.size() != 0) @(negedge i_clk);
    endtask

    // Writes both registers back to back; the bus stays selected between them.
    task automatic apply_settings(input logic run, input logic [DATA_W-1:0] rate);
        logic [DATA_W-1:0] vals [2];
        logic              idxs [2];
        vals[0] = {{(DATA_W-1){1'b0}}, run};
        vals[1] = rate;
        idxs[0] = REG_STARTED;
        idxs[1] = REG_TPS;
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= PADDR_W'(idxs[r]) << REG_IDX_BIT;
            pwdata  <= vals[r];
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            @(negedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.run_on    = run;
        sb.tick_rate = rate;
    endtask

    // Result receiver: random back-pressure, or a long hold-off on request.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len != 0) begin
                stall_left = hold_len;
                hold_len   = 0;
            end
            if (stall_left != 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen_beat.expired_valid   = out_ch.expired_valid;
            seen_beat.expired_task    = out_ch.expired_task;
            seen_beat.accepted        = out_ch.accepted;
            seen_beat.elapsed_ticks   = out_ch.elapsed_ticks;
            seen_beat.remaining_ticks = out_ch.remaining_ticks;
            seen_beat.last            = out_ch.last;
            sb.check_beat(seen_beat);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        sb = new();
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_TICK;
        in_ch.task_id     = '0;
        in_ch.delay_ticks = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The scheduler is still stopped after reset.
        send_command(CMD_TICK, 8'($urandom), $urandom);
        wait_drained();
        apply_settings(1'b1, 32'd1);
        send_command(CMD_TICK, 8'($urandom), $urandom);
        send_command(CMD_DELAY, 8'h00, 32'd0);
        send_command(CMD_DELAY, 8'hFF, 32'd1);
        send_command(CMD_DELAY, 8'h5A, 32'd3);
        // Both the head entry and the one behind it expire; 5A closes up.
        send_command(CMD_TICK, 8'($urandom), $urandom);
        for (int k = 0; k < 7; k++) send_command(CMD_DELAY, 8'(8'h10 + k), 32'd2);
        send_command(CMD_DELAY, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_TICK, 8'($urandom), $urandom);
        // A full bank empties in a single tick, one beat per timer.
        send_command(CMD_TICK, 8'($urandom), $urandom);
        send_command(CMD_TICK, 8'($urandom), $urandom);
        wait_drained();
        apply_settings(1'b0, 32'hFFFF_FFFF);
        send_command(CMD_DELAY, 8'hA5, 32'd0);
        send_command(CMD_TICK, 8'($urandom), $urandom);

        // Random part, one setting of the registers per phase.
        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    apply_settings(1'b1, TPS_RESET);
                end
                1: begin
                    apply_settings(1'b1, 32'hFFFF_FFFF);
                end
                2: begin
                    apply_settings(1'b1, 32'd1);
                end
                3: begin
                    apply_settings(1'b0, $urandom);
                end
                default: begin
                    apply_settings(1'b1, $urandom);
                end
            endcase
            steady = (ph == 1);
            if (ph == 2) hold_len = HOLD_CYCLES;
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // Long delays would never expire, so they are offered mostly
                // when the bank is full and the request gets refused.
                if ($urandom_range(99) < 50)
                    send_command(CMD_TICK, 8'($urandom), $urandom);
                else if (sb.live >= SLOTS || (ph == 4 && $urandom_range(99) < 20))
                    send_command(CMD_DELAY, 8'($urandom), $urandom);
                else
                    send_command(CMD_DELAY, 8'($urandom), $urandom_range(0, 12));
            end
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.pending_beats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dtb_pkg.sv
rtl/dtb_channels.sv
rtl/dtb_front.sv
rtl/dtb_queue.sv
rtl/dtb_engine.sv
rtl/delay_timer_bank.sv
tb/sv/delay_timer_bank_tb.sv
